### sv/btpa_pkg.sv
// ----------------------------------------------------------------------------
// Buddy tree allocator package
// Sizes, item kind codes, controller/datapath command and status bundles,
// and the order and tree-level helpers.
// ----------------------------------------------------------------------------
package btpa_pkg;

   // Tree geometry
   localparam int LEVELS   = 10;
   localparam int PAGES    = 1 << LEVELS;
   localparam int NODES    = (2 << LEVELS) - 1;
   localparam int NODE_W   = LEVELS + 1;
   localparam int V_W      = $clog2(LEVELS + 2);
   localparam int H_W      = $clog2(LEVELS + 1);

   // Field widths
   localparam int KIND_W   = 2;
   localparam int PAGE_W   = 10;
   localparam int CNT_W    = 11;
   localparam int FREE_W   = 11;
   localparam logic [FREE_W-1:0] FREE_MAX = '1;

   // Item kinds
   localparam logic [KIND_W-1:0] KIND_ADD   = 2'd0;
   localparam logic [KIND_W-1:0] KIND_ALLOC = 2'd1;
   localparam logic [KIND_W-1:0] KIND_FREE  = 2'd2;

   // Controller -> datapath
   typedef struct packed {
      logic clr_step;
      logic accept;
      logic init;
      logic desc;
      logic mark;
      logic lift;
      logic load_rsp;
   } cmd_type;

   // Datapath -> controller
   typedef struct packed {
      logic clr_last;
      logic item_ok;
      logic is_alloc;
      logic root_hit;
      logic top_level;
      logic top_exact;
      logic desc_found;
      logic desc_last;
      logic desc_exact;
      logic node_root;
      logic parent_root;
      logic rsp_free;
   } sts_type;

   // Block order: smallest k with 2^k >= count, capped at LEVELS
   function automatic logic [H_W-1:0] order_of(input logic [CNT_W-1:0] count);
      logic [CNT_W-1:0] m;
      logic [H_W-1:0]   k;
      m = count - 1'b1;
      k = '0;
      for (int b = 0; b < CNT_W; b++) begin
         if (m[b]) k = H_W'(b + 1);
      end
      if (k > H_W'(LEVELS)) k = H_W'(LEVELS);
      return k;
   endfunction

   // Heap index of the first node at height h
   function automatic logic [NODE_W-1:0] level_base(input logic [H_W-1:0] h);
      logic [NODE_W-1:0] one;
      one = NODE_W'(1);
      return (one << (H_W'(LEVELS) - h)) - one;
   endfunction

endpackage

### sv/btpa_ctrl.sv
// ----------------------------------------------------------------------------
// Buddy tree allocator controller
// Sequences the clearing sweep, the descent, the node write and the
// ancestor update, and hands the result to the output register.
// ----------------------------------------------------------------------------
module btpa_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  btpa_pkg::sts_type  sts,
   output btpa_pkg::cmd_type  cmd
);

   typedef enum logic [6:0] {
      ST_CLEAR = 7'b0000001,
      ST_IDLE  = 7'b0000010,
      ST_START = 7'b0000100,
      ST_DESC  = 7'b0001000,
      ST_MARK  = 7'b0010000,
      ST_LIFT  = 7'b0100000,
      ST_FIN   = 7'b1000000
   } state_type;

   state_type state_ff;
   state_type state_in;

   // Input side takes an item only when idle
   assign req_stall = (state_ff != ST_IDLE);

   // Next state and commands
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_CLEAR: begin
            cmd.clr_step = 1'b1;
            if (sts.clr_last) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (req_valid) begin
               cmd.accept = 1'b1;
               state_in   = ST_START;
            end
         end
         ST_START: begin
            cmd.init = 1'b1;
            if (!sts.item_ok) state_in = ST_FIN;
            else if (!sts.is_alloc) state_in = ST_MARK;
            else if (!sts.root_hit) state_in = ST_FIN;
            else if (sts.top_level) state_in = sts.top_exact ? ST_MARK : ST_FIN;
            else state_in = ST_DESC;
         end
         ST_DESC: begin
            cmd.desc = 1'b1;
            if (!sts.desc_found) state_in = ST_FIN;
            else if (sts.desc_last) state_in = sts.desc_exact ? ST_MARK : ST_FIN;
         end
         ST_MARK: begin
            cmd.mark = 1'b1;
            state_in = sts.node_root ? ST_FIN : ST_LIFT;
         end
         ST_LIFT: begin
            cmd.lift = 1'b1;
            if (sts.parent_root) state_in = ST_FIN;
         end
         ST_FIN: begin
            if (sts.rsp_free) begin
               cmd.load_rsp = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_CLEAR;
      endcase
   end

   // State register; reset starts the clearing sweep
   always_ff @(posedge clock) begin
      if (reset) state_ff <= ST_CLEAR;
      else state_ff <= state_in;
   end

endmodule

### sv/btpa_datapath.sv
// ----------------------------------------------------------------------------
// Buddy tree allocator datapath
// Node memory (two read ports, one write port), walk registers, free page
// counter and the result register.
// ----------------------------------------------------------------------------
module btpa_datapath (
   input  logic                          clock,
   input  logic                          reset,
   input  btpa_pkg::cmd_type             cmd,
   output btpa_pkg::sts_type             sts,
   input  logic [btpa_pkg::KIND_W-1:0]   req_kind,
   input  logic [btpa_pkg::PAGE_W-1:0]   req_page_index,
   input  logic [btpa_pkg::CNT_W-1:0]    req_count,
   input  logic                          rsp_stall,
   output logic                          rsp_valid,
   output logic                          rsp_ok,
   output logic [btpa_pkg::PAGE_W-1:0]   rsp_start_page,
   output logic [btpa_pkg::CNT_W-1:0]    rsp_granted_pages,
   output logic [btpa_pkg::FREE_W-1:0]   rsp_free_count
);

   localparam int NODE_W = btpa_pkg::NODE_W;
   localparam int V_W    = btpa_pkg::V_W;
   localparam int H_W    = btpa_pkg::H_W;
   localparam int PAGE_W = btpa_pkg::PAGE_W;
   localparam int CNT_W  = btpa_pkg::CNT_W;
   localparam int FREE_W = btpa_pkg::FREE_W;
   localparam int KIND_W = btpa_pkg::KIND_W;

   // Buddy of a node; the root maps to itself
   function automatic logic [NODE_W-1:0] sib_of(input logic [NODE_W-1:0] x);
      logic [NODE_W-1:0] s;
      if (x == '0) s = '0;
      else if (x[0]) s = x + 1'b1;
      else s = x - 1'b1;
      return s;
   endfunction

   // Node memory
   logic [V_W-1:0]    mem [btpa_pkg::NODES];
   logic              wr_en;
   logic [NODE_W-1:0] wr_addr;
   logic [V_W-1:0]    wr_data;
   logic [NODE_W-1:0] rd_a_addr;
   logic [NODE_W-1:0] rd_b_addr;
   logic [V_W-1:0]    rd_a_ff;
   logic [V_W-1:0]    rd_b_ff;

   // Item and walk registers
   logic [KIND_W-1:0] kind_ff,  kind_in;
   logic [PAGE_W-1:0] page_ff,  page_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [H_W-1:0]    k_ff,     k_in;
   logic [NODE_W-1:0] node_ff,  node_in;
   logic [H_W-1:0]    lvl_ff,   lvl_in;
   logic [V_W-1:0]    cur_ff,   cur_in;
   logic [V_W-1:0]    root_ff,  root_in;
   logic [FREE_W-1:0] free_ff,  free_in;
   logic [NODE_W-1:0] clr_addr_ff, clr_addr_in;

   // Result staging and output register
   logic              res_ok_ff,      res_ok_in;
   logic [PAGE_W-1:0] res_start_ff,   res_start_in;
   logic [CNT_W-1:0]  res_granted_ff, res_granted_in;
   logic              rsp_valid_ff,   rsp_valid_in;
   logic              rsp_ok_ff,      rsp_ok_in;
   logic [PAGE_W-1:0] rsp_start_ff,   rsp_start_in;
   logic [CNT_W-1:0]  rsp_granted_ff, rsp_granted_in;
   logic [FREE_W-1:0] rsp_free_ff,    rsp_free_in;

   // Combinational helpers
   logic              is_alloc;
   logic [V_W-1:0]    want;
   logic              left_ge, right_ge;
   logic [NODE_W-1:0] child_l, child_r, pick_node;
   logic [NODE_W-1:0] grand_l;
   logic [V_W-1:0]    pick_val;
   logic [H_W-1:0]    lvl_dn;
   logic [NODE_W-1:0] node_m1, parent;
   logic [V_W-1:0]    lvl_v, full_val, merged;
   logic [V_W-1:0]    mark_val;
   logic [CNT_W-1:0]  blk_pages;
   logic [PAGE_W-1:0] grant_start;
   logic [FREE_W:0]   free_sum;
   logic [FREE_W-1:0] free_add, free_sub;
   logic [NODE_W-1:0] init_node;
   logic              cnt_ok, page_ok, fit_ok, item_ok;

   assign is_alloc  = (kind_ff == btpa_pkg::KIND_ALLOC);
   assign want      = V_W'(k_ff) + 1'b1;

   // Descent: left child first, then right
   assign left_ge   = (rd_a_ff >= want);
   assign right_ge  = (rd_b_ff >= want);
   assign child_l   = {node_ff[NODE_W-2:0], 1'b1};
   assign child_r   = child_l + 1'b1;
   assign pick_node = left_ge ? child_l : child_r;
   assign pick_val  = left_ge ? rd_a_ff : rd_b_ff;
   assign grand_l   = {pick_node[NODE_W-2:0], 1'b1};
   assign lvl_dn    = lvl_ff - 1'b1;

   // Ancestor update: parent from current node and its buddy
   assign node_m1   = node_ff - 1'b1;
   assign parent    = {1'b0, node_m1[NODE_W-1:1]};
   assign lvl_v     = V_W'(lvl_ff);
   assign full_val  = lvl_v + 1'b1;
   assign merged    = (cur_ff == full_val && rd_a_ff == full_val) ? lvl_v + 2'd2 :
                      ((cur_ff > rd_a_ff) ? cur_ff : rd_a_ff);

   // Node value written at the target, block size and start page
   assign mark_val    = is_alloc ? '0 : want;
   assign blk_pages   = CNT_W'(1) << k_ff;
   assign grant_start = PAGE_W'((node_ff - btpa_pkg::level_base(k_ff)) << k_ff);
   assign init_node   = btpa_pkg::level_base(k_ff) + NODE_W'(page_ff >> k_ff);

   // Saturating free page count
   assign free_sum = {1'b0, free_ff} + {1'b0, FREE_W'(blk_pages)};
   assign free_add = free_sum[FREE_W] ? btpa_pkg::FREE_MAX : free_sum[FREE_W-1:0];
   assign free_sub = (free_ff > FREE_W'(blk_pages)) ? free_ff - FREE_W'(blk_pages) : '0;

   // Item checks
   assign cnt_ok  = (count_ff != '0) && (count_ff <= CNT_W'(btpa_pkg::PAGES));
   assign page_ok = ({1'b0, page_ff} < (PAGE_W + 1)'(btpa_pkg::PAGES));
   assign fit_ok  = (FREE_W'(count_ff) <= free_ff);

   always_comb begin
      unique case (kind_ff)
         btpa_pkg::KIND_ADD:   item_ok = page_ok;
         btpa_pkg::KIND_ALLOC: item_ok = cnt_ok && fit_ok;
         btpa_pkg::KIND_FREE:  item_ok = cnt_ok && page_ok;
         default:              item_ok = 1'b0;
      endcase
   end

   // Memory port selection
   always_comb begin
      wr_en     = 1'b0;
      wr_addr   = '0;
      wr_data   = '0;
      rd_a_addr = '0;
      rd_b_addr = '0;
      if (cmd.clr_step) begin
         wr_en   = 1'b1;
         wr_addr = clr_addr_ff;
      end
      if (cmd.init) begin
         rd_a_addr = NODE_W'(1);
         rd_b_addr = NODE_W'(2);
      end
      if (cmd.desc && (lvl_dn != k_ff)) begin
         rd_a_addr = grand_l;
         rd_b_addr = grand_l + 1'b1;
      end
      if (cmd.mark) begin
         wr_en     = 1'b1;
         wr_addr   = node_ff;
         wr_data   = mark_val;
         rd_a_addr = sib_of(node_ff);
      end
      if (cmd.lift) begin
         wr_en     = 1'b1;
         wr_addr   = parent;
         wr_data   = merged;
         rd_a_addr = sib_of(parent);
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      rd_a_ff <= mem[rd_a_addr];
      rd_b_ff <= mem[rd_b_addr];
   end

   // Next values
   always_comb begin
      kind_in        = kind_ff;
      page_in        = page_ff;
      count_in       = count_ff;
      k_in           = k_ff;
      node_in        = node_ff;
      lvl_in         = lvl_ff;
      cur_in         = cur_ff;
      root_in        = root_ff;
      free_in        = free_ff;
      clr_addr_in    = clr_addr_ff;
      res_ok_in      = res_ok_ff;
      res_start_in   = res_start_ff;
      res_granted_in = res_granted_ff;
      rsp_valid_in   = rsp_valid_ff && rsp_stall;
      rsp_ok_in      = rsp_ok_ff;
      rsp_start_in   = rsp_start_ff;
      rsp_granted_in = rsp_granted_ff;
      rsp_free_in    = rsp_free_ff;

      if (cmd.clr_step) clr_addr_in = clr_addr_ff + 1'b1;
      if (wr_en && wr_addr == '0) root_in = wr_data;

      // capture item; an added page is a block of order zero
      if (cmd.accept) begin
         kind_in  = req_kind;
         page_in  = req_page_index;
         count_in = req_count;
         k_in     = (req_kind == btpa_pkg::KIND_ADD) ? '0 : btpa_pkg::order_of(req_count);
      end

      // start of walk
      if (cmd.init) begin
         res_ok_in      = 1'b0;
         res_start_in   = '0;
         res_granted_in = '0;
         if (is_alloc) begin
            node_in = '0;
            lvl_in  = H_W'(btpa_pkg::LEVELS);
            cur_in  = root_ff;
         end else begin
            node_in = init_node;
            lvl_in  = k_ff;
         end
      end

      // one level down
      if (cmd.desc) begin
         node_in = pick_node;
         cur_in  = pick_val;
         lvl_in  = lvl_dn;
      end

      // write the target node and settle the page count
      if (cmd.mark) begin
         cur_in    = mark_val;
         res_ok_in = 1'b1;
         if (is_alloc) begin
            res_start_in   = grant_start;
            res_granted_in = blk_pages;
            free_in        = free_sub;
         end else begin
            free_in = free_add;
         end
      end

      // one level up
      if (cmd.lift) begin
         node_in = parent;
         cur_in  = merged;
         lvl_in  = lvl_ff + 1'b1;
      end

      if (cmd.load_rsp) begin
         rsp_valid_in   = 1'b1;
         rsp_ok_in      = res_ok_ff;
         rsp_start_in   = res_start_ff;
         rsp_granted_in = res_granted_ff;
         rsp_free_in    = free_ff;
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         root_ff      <= '0;
         free_ff      <= '0;
         clr_addr_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         root_ff      <= root_in;
         free_ff      <= free_in;
         clr_addr_ff  <= clr_addr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      kind_ff        <= kind_in;
      page_ff        <= page_in;
      count_ff       <= count_in;
      k_ff           <= k_in;
      node_ff        <= node_in;
      lvl_ff         <= lvl_in;
      cur_ff         <= cur_in;
      res_ok_ff      <= res_ok_in;
      res_start_ff   <= res_start_in;
      res_granted_ff <= res_granted_in;
      rsp_ok_ff      <= rsp_ok_in;
      rsp_start_ff   <= rsp_start_in;
      rsp_granted_ff <= rsp_granted_in;
      rsp_free_ff    <= rsp_free_in;
   end

   // Status to controller
   always_comb begin
      sts             = '0;
      sts.clr_last    = (clr_addr_ff == NODE_W'(btpa_pkg::NODES - 1));
      sts.item_ok     = item_ok;
      sts.is_alloc    = is_alloc;
      sts.root_hit    = (root_ff >= want);
      sts.top_level   = (k_ff == H_W'(btpa_pkg::LEVELS));
      sts.top_exact   = (root_ff == want);
      sts.desc_found  = left_ge || right_ge;
      sts.desc_last   = (lvl_dn == k_ff);
      sts.desc_exact  = (pick_val == want);
      sts.node_root   = (node_ff == '0);
      sts.parent_root = (parent == '0);
      sts.rsp_free    = !rsp_valid_ff || !rsp_stall;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_ok            = rsp_ok_ff;
   assign rsp_start_page    = rsp_start_ff;
   assign rsp_granted_pages = rsp_granted_ff;
   assign rsp_free_count    = rsp_free_ff;

`ifndef ASSERT_OFF
   // a granted block is only reported on success
   a_grant_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_granted_ff != '0 |-> rsp_ok_ff)
      else $error("granted pages on a failed item");

   // output register fills only through a controller load
   a_rsp_load: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(cmd.load_rsp))
      else $error("result appeared without a load");

   // a parent never exceeds a wholly free block of its height
   a_merge_bound: assert property (@(posedge clock) disable iff (reset)
      cmd.lift |-> merged <= lvl_v + 2'd2)
      else $error("ancestor value out of range");

   // an allocation never raises the free page count
   a_alloc_free: assert property (@(posedge clock) disable iff (reset)
      cmd.mark && is_alloc |=> free_ff <= $past(free_ff))
      else $error("free count grew on allocation");
`endif

endmodule

### sv/buddy_tree_page_allocator.sv
// ----------------------------------------------------------------------------
// Buddy tree page allocator
// Binary buddy allocator over 2^LEVELS pages kept as a heap-ordered tree of
// largest-free-block codes: add a page, allocate a block, free a block.
//
//   channel | ports                                         | direction
//   --------+-----------------------------------------------+----------
//   req     | req_valid req_stall req_kind req_page_index    | in
//           | req_count                                     |
//   rsp     | rsp_valid rsp_stall rsp_ok rsp_start_page      | out
//           | rsp_granted_pages rsp_free_count              |
//
// Allocation: after accept the walk makes one descent step and one ancestor
//   write per level on the node memory, from the root down to k, the block
//   order, and back up; then the result goes to the output register.
// Add or free: the target node is written, then one ancestor per level up to
//   the root. A rejected item skips the walk, a failed allocation ends early.
// One item in flight; the next is taken once the result is in the output
// register, which holds while rsp_stall is high.
// After reset the node memory is cleared, one node a cycle, all NODES = 2047
//   nodes, with req_stall high.
// ----------------------------------------------------------------------------
module buddy_tree_page_allocator (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [btpa_pkg::KIND_W-1:0]   req_kind,
   input  logic [btpa_pkg::PAGE_W-1:0]   req_page_index,
   input  logic [btpa_pkg::CNT_W-1:0]    req_count,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic                          rsp_ok,
   output logic [btpa_pkg::PAGE_W-1:0]   rsp_start_page,
   output logic [btpa_pkg::CNT_W-1:0]    rsp_granted_pages,
   output logic [btpa_pkg::FREE_W-1:0]   rsp_free_count
);

   btpa_pkg::cmd_type cmd;
   btpa_pkg::sts_type sts;

   // Sequencer
   btpa_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   // Node memory and counters
   btpa_datapath u_datapath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .sts               (sts),
      .req_kind          (req_kind),
      .req_page_index    (req_page_index),
      .req_count         (req_count),
      .rsp_stall         (rsp_stall),
      .rsp_valid         (rsp_valid),
      .rsp_ok            (rsp_ok),
      .rsp_start_page    (rsp_start_page),
      .rsp_granted_pages (rsp_granted_pages),
      .rsp_free_count    (rsp_free_count)
   );

endmodule
